// ----- src/crr_pkg.sv -----
// Shared types and field widths for the cascaded range remap pipeline.
package crr_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned StageWidth = 3;
   localparam int unsigned SlotWidth  = 6;
   localparam int unsigned ReqWidth   = 144;

   typedef enum logic {
      REQ_LOAD      = 1'b0,
      REQ_TRANSLATE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                   valid;
      req_kind_type           kind;
      logic [StageWidth-1:0]  stage_sel;
      logic [SlotWidth-1:0]   entry_sel;
      logic [WordWidth-1:0]   dest_base;
      logic [WordWidth-1:0]   source_base;
      logic [WordWidth-1:0]   window_length;
      logic [WordWidth-1:0]   value;
   } item_type;

endpackage

// ----- src/crr_stage.sv -----
// One translation stage: range table, parallel window compare and rebase.
module crr_stage #(
   parameter int STAGE_ID = 0,
   parameter int ENTRIES  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  crr_pkg::item_type item_in,
   output crr_pkg::item_type item_out
);
   import crr_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [WordWidth-1:0] dest_ff   [ENTRIES];
   logic [WordWidth-1:0] source_ff [ENTRIES];
   logic [WordWidth-1:0] length_ff [ENTRIES];
   logic [ENTRIES-1:0]   entry_valid_ff;

   item_type             a_item_ff;
   logic                 a_hit_ff, a_hit_in;
   logic [WordWidth-1:0] a_src_ff, a_src_in;
   logic [WordWidth-1:0] a_dest_ff, a_dest_in;
   item_type             b_item_ff, b_item_in;

   logic [8:0]    slot_ext;
   logic [IW-1:0] slot_idx;
   logic          load_hit;
   logic [ENTRIES-1:0] hit_vec;

   assign slot_ext = {3'b000, item_in.entry_sel};
   assign slot_idx = slot_ext[IW-1:0];
   assign load_hit = enable && item_in.valid && (item_in.kind == REQ_LOAD)
                     && ({1'b0, item_in.stage_sel} == 4'(STAGE_ID))
                     && (slot_ext < 9'(ENTRIES));

   always_comb begin
      for (int e = 0; e < ENTRIES; e++) begin
         hit_vec[e] = entry_valid_ff[e]
                      && (item_in.value >= source_ff[e])
                      && ({1'b0, item_in.value} <
                          ({1'b0, source_ff[e]} + {1'b0, length_ff[e]}));
      end
      a_hit_in  = 1'b0;
      a_src_in  = '0;
      a_dest_in = '0;
      for (int e = ENTRIES - 1; e >= 0; e--) begin
         if (hit_vec[e]) begin
            a_hit_in  = 1'b1;
            a_src_in  = source_ff[e];
            a_dest_in = dest_ff[e];
         end
      end
      a_hit_in = a_hit_in && item_in.valid && (item_in.kind == REQ_TRANSLATE);
   end

   always_comb begin
      b_item_in = a_item_ff;
      if (a_hit_ff) begin
         b_item_in.value = a_dest_ff + (a_item_ff.value - a_src_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         dest_ff[slot_idx]   <= item_in.dest_base;
         source_ff[slot_idx] <= item_in.source_base;
         length_ff[slot_idx] <= item_in.window_length;
      end
      if (reset) begin
         entry_valid_ff  <= '0;
         a_hit_ff        <= 1'b0;
         a_item_ff.valid <= 1'b0;
         b_item_ff.valid <= 1'b0;
      end else begin
         if (load_hit) begin
            entry_valid_ff[slot_idx] <= 1'b1;
         end
         if (enable) begin
            a_item_ff <= item_in;
            a_src_ff  <= a_src_in;
            a_dest_ff <= a_dest_in;
            b_item_ff <= b_item_in;
            a_hit_ff  <= a_hit_in;
         end
      end
   end

   assign item_out = b_item_ff;

   a_load_marks_valid: assert property (@(posedge clock) disable iff (reset)
      load_hit |=> entry_valid_ff[$past(slot_idx)])
      else $error("loaded slot not marked valid");

   a_hit_only_translate: assert property (@(posedge clock) disable iff (reset)
      a_hit_ff |-> (a_item_ff.valid && a_item_ff.kind == REQ_TRANSLATE))
      else $error("hit flagged on a non-translate slot");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !enable |=> ($stable(b_item_ff) && $stable(a_hit_ff)))
      else $error("stage moved while stalled");

endmodule

// ----- src/cascaded_range_remap.sv -----
// Top level of the cascaded range remap: request/response streams over a stage chain.
// Requests enter on req_*: tuser is the kind (0 load entry, 1 translate value),
// tdata carries the entry fields and the query value. Each translate request
// yields one response on rsp_* holding the mapped value; load requests yield
// none. Requests and responses keep their order.
// Each stage registers its window compare with first-match pick and then its
// rebase add, and a translate response passes through these registers in
// every stage in turn; one request may enter every cycle while the receiver
// is not stalling a response. A load writes its stage's table when it
// reaches that stage, so it affects only requests behind it.
// Reset clears every entry valid bit and empties the pipeline at once.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated.
module cascaded_range_remap #(
   parameter int STAGES  = 7,
   parameter int ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [2:0] stage_sel, [8:3] entry_sel, [40:9] dest_base, [72:41] source_base,
   // [104:73] window_length, [136:105] query_value, [143:137] zero
   input  logic [crr_pkg::ReqWidth-1:0] req_tdata,
   // [0] req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] mapped_value
   output logic [crr_pkg::WordWidth-1:0] rsp_tdata
);
   import crr_pkg::*;

   item_type chain [STAGES+1];
   item_type req_item;
   logic     enable;

   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   always_comb begin
      req_item.valid         = req_tvalid;
      req_item.kind          = req_kind_type'(req_tuser);
      req_item.stage_sel     = req_tdata[2:0];
      req_item.entry_sel     = req_tdata[8:3];
      req_item.dest_base     = req_tdata[40:9];
      req_item.source_base   = req_tdata[72:41];
      req_item.window_length = req_tdata[104:73];
      req_item.value         = req_tdata[136:105];
   end

   assign chain[0] = req_item;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      crr_stage #(.STAGE_ID(s), .ENTRIES(ENTRIES)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .item_in  (chain[s]),
         .item_out (chain[s+1])
      );
   end

   assign rsp_tvalid = chain[STAGES].valid && (chain[STAGES].kind == REQ_TRANSLATE);
   assign rsp_tdata  = chain[STAGES].value;

endmodule
